[hdl/ppif_pkg.sv]
package ppif_pkg;

  localparam int ANGLE_W = 16;
  localparam int POS_W   = 24;
  localparam int LVL_W   = 32;
  localparam int TOT_W   = 24;
  localparam int GAIN_W  = 16;
  localparam int BOX_W   = 8;
  localparam int FRAC_W  = 16;
  localparam int SPD_W   = 24;
  localparam int DT_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register reset values
  localparam logic [BOX_W-1:0]  BOX_RST  = 8'd15;
  localparam logic [TOT_W-1:0]  HTOT_RST = 24'd6553600;
  localparam logic [TOT_W-1:0]  PTOT_RST = 24'd65536;
  localparam logic [GAIN_W-1:0] INH_RST  = 16'd13107;
  localparam logic [GAIN_W-1:0] INJ_RST  = 16'd26214;

  // Calibrated level after reset: one tenth of each total, rounded
  localparam logic [LVL_W-1:0] HLVL_TENTH = 32'd655360;
  localparam logic [LVL_W-1:0] PLVL_TENTH = 32'd6554;

  localparam logic [LVL_W-1:0] LEVEL_FLOOR = 32'd7;
  localparam logic [LVL_W-1:0] LEVEL_CAP   = 32'h07FF_FFFF;

  // Sine polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42047;
  localparam logic [15:0] SIN_C = 16'd4640;
  localparam logic [16:0] SIN_ONE = 17'd65536;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX  = 3'd0,
    CFG_HTOT = 3'd1,
    CFG_PTOT = 3'd2,
    CFG_INH  = 3'd3,
    CFG_INJ  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_MOTION = 2'd0,
    CMD_CALIB  = 2'd1,
    CMD_RESET  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MOD_GO, S_MOD_WT,
    S_H_MUL, S_H_ADD,
    S_SIN_ZZ, S_SIN_A, S_SIN_B, S_SIN_C, S_SIN_D,
    S_M_MUL, S_M_HOLD, S_P_LO, S_P_HI, S_P_ACC,
    S_INH_MUL, S_INH_CL, S_RN_I, S_RN_IW, S_RN_CM, S_RN_C, S_RN_CW,
    S_CAL_INJ, S_CAL_INJH,
    S_FU_X, S_FU_Y, S_FU_DIV, S_FU_W,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [BOX_W-1:0]  box;
    logic [TOT_W-1:0]  htot;
    logic [TOT_W-1:0]  ptot;
    logic [GAIN_W-1:0] inh;
    logic [GAIN_W-1:0] inj;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [SPD_W-1:0]   speed;
    logic [SPD_W-1:0]   turn_rate;
    logic [DT_W-1:0]    step_time;
    logic [ANGLE_W-1:0] cue_heading;
    logic [POS_W-1:0]   cue_x;
    logic [POS_W-1:0]   cue_y;
  } item_t;

  typedef struct packed {
    logic [LVL_W-1:0]   y_level;
    logic [LVL_W-1:0]   x_level;
    logic [LVL_W-1:0]   heading_level;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   x;
    logic [ANGLE_W-1:0] heading;
  } est_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [33:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [33:0] rem;
  } div_rsp_t;

endpackage

[hdl/ppif_mul.sv]
module ppif_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  logic [63:0] p_r;

  // Register the product
  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end

  assign p = p_r;

endmodule

[hdl/ppif_div.sv]
module ppif_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ppif_pkg::div_req_t req,
  output ppif_pkg::div_rsp_t rsp
);

  // Restoring divider, one quotient bit a cycle; dividend must stay
  // below divisor * 2^32
  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [33:0] rem_r;
  logic [31:0] quo_r;
  logic [33:0] dvs_r;
  logic [34:0] trial;
  logic        ge;

  assign trial = {rem_r, quo_r[31]};
  assign ge    = trial >= {1'b0, dvs_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {2'b00, req.dividend[63:32]};
      quo_r <= req.dividend[31:0];
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? 34'(trial - {1'b0, dvs_r}) : trial[33:0];
      quo_r <= {quo_r[30:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

[hdl/ppif_seq.sv]
module ppif_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ppif_pkg::item_t item,
  input  ppif_pkg::cfg_t  cfg,
  input  logic            ack,
  output logic            idle,
  output logic            done,
  output ppif_pkg::est_t  est
);

  ppif_pkg::state_t state_r, state_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [23:0] spd_r, spd_nxt, trn_r, trn_nxt;
  logic [15:0] dt_r, dt_nxt, cueh_r, cueh_nxt;
  logic [23:0] cuex_r, cuex_nxt, cuey_r, cuey_nxt;
  logic [15:0] ih_r, ih_nxt, ch_r, ch_nxt, eh_r, eh_nxt;
  logic [23:0] ip_r [2], ip_nxt [2], cp_r [2], cp_nxt [2], ep_r [2], ep_nxt [2];
  logic [31:0] il_r [3], il_nxt [3], cl_r [3], cl_nxt [3], el_r [3], el_nxt [3];
  logic [16:0] x2_r, x2_nxt;
  logic [16:0] trig_r [2], trig_nxt [2];
  logic        tneg_r [2], tneg_nxt [2];
  logic [39:0] m_r, m_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [32:0] sum_r, sum_nxt;
  logic [23:0] inj_r, inj_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] p;
  ppif_pkg::div_req_t div_req;
  ppif_pkg::div_rsp_t div_rsp;

  logic [7:0]  box_e;
  logic [23:0] period;
  logic [1:0]  kk;
  logic        pidx;
  logic [23:0] tot_k;
  logic [15:0] ta;
  logic [14:0] z;
  logic [23:0] spd_abs, trn_abs;

  logic [23:0] fa, fb;
  logic [31:0] fla, flb;
  logic [24:0] fper, fhalf, fx, fy;
  logic [32:0] fsum;

  ppif_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));
  ppif_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  function automatic logic [23:0] step_pos(input logic [23:0] pv, input logic [25:0] mag_in,
                                           input logic neg, input logic [23:0] per);
    logic [25:0] mag;
    logic [25:0] lim;
    logic [25:0] v;
    begin
      lim = {2'b00, per} - 26'd1;
      mag = (mag_in > lim) ? lim : mag_in;
      if (neg) begin
        if ({2'b00, pv} >= mag) v = {2'b00, pv} - mag;
        else v = {2'b00, pv} + {2'b00, per} - mag;
      end else begin
        v = {2'b00, pv} + mag;
        if (v >= {2'b00, per}) v = v - {2'b00, per};
      end
      step_pos = v[23:0];
    end
  endfunction

  // Operand selection shared by several steps
  always_comb begin
    box_e   = (cfg.box == 8'd0) ? 8'd1 : cfg.box;
    period  = {box_e, 16'h0000};
    kk      = k_r[1:0];
    pidx    = k_r[1];
    if (kk == 2'd0) tot_k = (cfg.htot == 24'd0) ? 24'd1 : cfg.htot;
    else tot_k = (cfg.ptot == 24'd0) ? 24'd1 : cfg.ptot;
    ta      = ih_r + (k_r[0] ? 16'h0000 : ppif_pkg::QUARTER_TURN);
    z       = ta[14] ? 15'(15'd16384 - {1'b0, ta[13:0]}) : {1'b0, ta[13:0]};
    spd_abs = spd_r[23] ? 24'(-spd_r) : spd_r;
    trn_abs = trn_r[23] ? 24'(-trn_r) : trn_r;

    // Fusion operands: estimate from the two hypotheses, or cue into calibrated
    if (cmd_r == ppif_pkg::CMD_CALIB) begin
      fa  = (kk == 2'd0) ? {8'h00, ch_r} : cp_r[pidx];
      fb  = (kk == 2'd0) ? {8'h00, cueh_r} : (pidx ? cuey_r : cuex_r);
      fla = cl_r[kk];
      flb = {8'h00, inj_r};
    end else begin
      fa  = (kk == 2'd0) ? {8'h00, ih_r} : ip_r[pidx];
      fb  = (kk == 2'd0) ? {8'h00, ch_r} : cp_r[pidx];
      fla = il_r[kk];
      flb = cl_r[kk];
    end
    fper  = (kk == 2'd0) ? 25'h001_0000 : {1'b0, period};
    fhalf = fper >> 1;
    fx    = {1'b0, fa};
    fy    = {1'b0, fb};
    if (fx > fy && (fx - fy) > fhalf) fy = fy + fper;
    else if (fy > fx && (fy - fx) > fhalf) fx = fx + fper;
    fsum  = {1'b0, fla} + {1'b0, flb};
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    logic [63:0] prod;
    logic [31:0] sub;
    logic [31:0] cln;
    logic [16:0] s17;
    logic [17:0] s18;
    logic [25:0] mag;
    logic [31:0] fq;
    logic [23:0] fmean;
    logic        fwr;
    logic [32:0] nl;
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd_nxt   = cmd_r;
    spd_nxt   = spd_r;
    trn_nxt   = trn_r;
    dt_nxt    = dt_r;
    cueh_nxt  = cueh_r;
    cuex_nxt  = cuex_r;
    cuey_nxt  = cuey_r;
    ih_nxt    = ih_r;
    ch_nxt    = ch_r;
    eh_nxt    = eh_r;
    ip_nxt    = ip_r;
    cp_nxt    = cp_r;
    ep_nxt    = ep_r;
    il_nxt    = il_r;
    cl_nxt    = cl_r;
    el_nxt    = el_r;
    x2_nxt    = x2_r;
    trig_nxt  = trig_r;
    tneg_nxt  = tneg_r;
    m_nxt     = m_r;
    acc_nxt   = acc_r;
    sum_nxt   = sum_r;
    inj_nxt   = inj_r;
    mul_a     = '0;
    mul_b     = '0;
    div_req   = '0;
    prod      = '0;
    sub       = '0;
    cln       = '0;
    s17       = '0;
    s18       = '0;
    mag       = '0;
    fq        = div_rsp.quo;
    fmean     = '0;
    fwr       = 1'b0;
    nl        = '0;

    unique case (state_r)
      ppif_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt   = item.cmd;
          spd_nxt   = item.speed;
          trn_nxt   = item.turn_rate;
          dt_nxt    = item.step_time;
          cueh_nxt  = item.cue_heading;
          cuex_nxt  = item.cue_x;
          cuey_nxt  = item.cue_y;
          k_nxt     = 3'd0;
          state_nxt = ppif_pkg::S_MOD_GO;
        end
      end

      // Reduce stored positions and cues modulo the current period
      ppif_pkg::S_MOD_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = {10'd0, period};
        case (k_r)
          3'd0:    div_req.dividend = {40'd0, ip_r[0]};
          3'd1:    div_req.dividend = {40'd0, ip_r[1]};
          3'd2:    div_req.dividend = {40'd0, cp_r[0]};
          3'd3:    div_req.dividend = {40'd0, cp_r[1]};
          3'd4:    div_req.dividend = {40'd0, cuex_r};
          default: div_req.dividend = {40'd0, cuey_r};
        endcase
        state_nxt = ppif_pkg::S_MOD_WT;
      end

      ppif_pkg::S_MOD_WT: begin
        if (div_rsp.done) begin
          case (k_r)
            3'd0:    ip_nxt[0] = div_rsp.rem[23:0];
            3'd1:    ip_nxt[1] = div_rsp.rem[23:0];
            3'd2:    cp_nxt[0] = div_rsp.rem[23:0];
            3'd3:    cp_nxt[1] = div_rsp.rem[23:0];
            3'd4:    cuex_nxt  = div_rsp.rem[23:0];
            default: cuey_nxt  = div_rsp.rem[23:0];
          endcase
          if (k_r == 3'd5) begin
            k_nxt = 3'd0;
            case (cmd_r)
              ppif_pkg::CMD_MOTION: state_nxt = ppif_pkg::S_H_MUL;
              ppif_pkg::CMD_CALIB:  state_nxt = ppif_pkg::S_CAL_INJ;
              ppif_pkg::CMD_RESET: begin
                ch_nxt    = ih_r;
                cp_nxt[0] = ip_r[0];
                cp_nxt[1] = ip_r[1];
                cl_nxt[0] = ppif_pkg::LEVEL_FLOOR;
                cl_nxt[1] = ppif_pkg::LEVEL_FLOOR;
                cl_nxt[2] = ppif_pkg::LEVEL_FLOOR;
                state_nxt = ppif_pkg::S_DONE;
              end
              default: state_nxt = ppif_pkg::S_DONE;
            endcase
          end else begin
            k_nxt     = k_r + 3'd1;
            state_nxt = ppif_pkg::S_MOD_GO;
          end
        end
      end

      // Heading step
      ppif_pkg::S_H_MUL: begin
        mul_a     = {8'h00, trn_abs};
        mul_b     = {16'h0000, dt_r};
        state_nxt = ppif_pkg::S_H_ADD;
      end

      ppif_pkg::S_H_ADD: begin
        prod      = trn_r[23] ? 64'(-p) : p;
        ih_nxt    = ih_r + prod[31:16];
        ch_nxt    = ch_r + prod[31:16];
        k_nxt     = 3'd0;
        state_nxt = ppif_pkg::S_SIN_ZZ;
      end

      // Cosine (k=0) then sine (k=1) of the new integrated heading
      ppif_pkg::S_SIN_ZZ: begin
        mul_a     = {17'd0, z};
        mul_b     = {17'd0, z};
        state_nxt = ppif_pkg::S_SIN_A;
      end

      ppif_pkg::S_SIN_A: begin
        x2_nxt    = p[28:12];
        mul_a     = {16'h0000, ppif_pkg::SIN_C};
        mul_b     = {15'd0, p[28:12]};
        state_nxt = ppif_pkg::S_SIN_B;
      end

      ppif_pkg::S_SIN_B: begin
        mul_a     = {16'h0000, 16'(ppif_pkg::SIN_B - p[31:16])};
        mul_b     = {15'd0, x2_r};
        state_nxt = ppif_pkg::S_SIN_C;
      end

      ppif_pkg::S_SIN_C: begin
        mul_a     = {15'd0, 17'(ppif_pkg::SIN_A - p[32:16])};
        mul_b     = {17'd0, z};
        state_nxt = ppif_pkg::S_SIN_D;
      end

      ppif_pkg::S_SIN_D: begin
        s18 = p[31:14];
        s17 = (s18 > {1'b0, ppif_pkg::SIN_ONE}) ? ppif_pkg::SIN_ONE : s18[16:0];
        trig_nxt[k_r[0]] = s17;
        tneg_nxt[k_r[0]] = ta[15] && (s17 != 17'd0);
        if (k_r[0]) begin
          k_nxt     = 3'd0;
          state_nxt = ppif_pkg::S_M_MUL;
        end else begin
          k_nxt     = 3'd1;
          state_nxt = ppif_pkg::S_SIN_ZZ;
        end
      end

      // Distance |speed| * step_time, then one axis at a time
      ppif_pkg::S_M_MUL: begin
        mul_a     = {8'h00, spd_abs};
        mul_b     = {16'h0000, dt_r};
        state_nxt = ppif_pkg::S_M_HOLD;
      end

      ppif_pkg::S_M_HOLD: begin
        m_nxt     = p[39:0];
        state_nxt = ppif_pkg::S_P_LO;
      end

      ppif_pkg::S_P_LO: begin
        mul_a     = m_r[31:0];
        mul_b     = {15'd0, trig_r[k_r[0]]};
        state_nxt = ppif_pkg::S_P_HI;
      end

      ppif_pkg::S_P_HI: begin
        acc_nxt   = p;
        mul_a     = {24'h000000, m_r[39:32]};
        mul_b     = {15'd0, trig_r[k_r[0]]};
        state_nxt = ppif_pkg::S_P_ACC;
      end

      ppif_pkg::S_P_ACC: begin
        mag = p[25:0] + {9'd0, acc_r[48:32]};
        ip_nxt[k_r[0]] = step_pos(ip_r[k_r[0]], mag, spd_r[23] ^ tneg_r[k_r[0]], period);
        cp_nxt[k_r[0]] = step_pos(cp_r[k_r[0]], mag, spd_r[23] ^ tneg_r[k_r[0]], period);
        if (k_r[0]) begin
          k_nxt     = 3'd0;
          state_nxt = ppif_pkg::S_INH_MUL;
        end else begin
          k_nxt     = 3'd1;
          state_nxt = ppif_pkg::S_P_LO;
        end
      end

      // Inhibition and renormalisation, one axis at a time
      ppif_pkg::S_INH_MUL: begin
        mul_a     = il_r[kk];
        mul_b     = {16'h0000, cfg.inh};
        state_nxt = ppif_pkg::S_INH_CL;
      end

      ppif_pkg::S_INH_CL: begin
        sub = p[47:16];
        if (cl_r[kk] <= sub) cln = ppif_pkg::LEVEL_FLOOR;
        else begin
          cln = cl_r[kk] - sub;
          if (cln > {8'h00, tot_k}) cln = {8'h00, tot_k};
        end
        cl_nxt[kk] = cln;
        sum_nxt    = {1'b0, il_r[kk]} + {1'b0, cln};
        mul_a      = {8'h00, tot_k};
        mul_b      = il_r[kk];
        state_nxt  = ppif_pkg::S_RN_I;
      end

      ppif_pkg::S_RN_I: begin
        div_req.start    = 1'b1;
        div_req.dividend = p;
        div_req.divisor  = {1'b0, sum_r};
        state_nxt        = ppif_pkg::S_RN_IW;
      end

      ppif_pkg::S_RN_IW: begin
        if (div_rsp.done) begin
          il_nxt[kk] = div_rsp.quo;
          state_nxt  = ppif_pkg::S_RN_CM;
        end
      end

      ppif_pkg::S_RN_CM: begin
        mul_a     = {8'h00, tot_k};
        mul_b     = cl_r[kk];
        state_nxt = ppif_pkg::S_RN_C;
      end

      ppif_pkg::S_RN_C: begin
        div_req.start    = 1'b1;
        div_req.dividend = p;
        div_req.divisor  = {1'b0, sum_r};
        state_nxt        = ppif_pkg::S_RN_CW;
      end

      ppif_pkg::S_RN_CW: begin
        if (div_rsp.done) begin
          cl_nxt[kk] = div_rsp.quo;
          el_nxt[kk] = il_r[kk] + div_rsp.quo;
          if (kk == 2'd2) begin
            k_nxt     = 3'd0;
            state_nxt = ppif_pkg::S_FU_X;
          end else begin
            k_nxt     = k_r + 3'd1;
            state_nxt = ppif_pkg::S_INH_MUL;
          end
        end
      end

      // Injection level for a calibration cue
      ppif_pkg::S_CAL_INJ: begin
        mul_a     = {8'h00, tot_k};
        mul_b     = {16'h0000, cfg.inj};
        state_nxt = ppif_pkg::S_CAL_INJH;
      end

      ppif_pkg::S_CAL_INJH: begin
        inj_nxt   = p[39:16];
        state_nxt = ppif_pkg::S_FU_X;
      end

      // Weighted circular mean
      ppif_pkg::S_FU_X: begin
        if (fsum == 33'd0) begin
          fwr   = 1'b1;
          fmean = fa;
        end else begin
          mul_a     = {7'd0, fx};
          mul_b     = fla;
          state_nxt = ppif_pkg::S_FU_Y;
        end
      end

      ppif_pkg::S_FU_Y: begin
        acc_nxt   = p;
        mul_a     = {7'd0, fy};
        mul_b     = flb;
        state_nxt = ppif_pkg::S_FU_DIV;
      end

      ppif_pkg::S_FU_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc_r + p;
        div_req.divisor  = {1'b0, fsum};
        state_nxt        = ppif_pkg::S_FU_W;
      end

      ppif_pkg::S_FU_W: begin
        if (div_rsp.done) begin
          fwr = 1'b1;
          if (fq >= {7'd0, fper}) fq = fq - {7'd0, fper};
          fmean = fq[23:0];
        end
      end

      ppif_pkg::S_DONE: begin
        if (ack) state_nxt = ppif_pkg::S_IDLE;
      end

      default: state_nxt = ppif_pkg::S_IDLE;
    endcase

    // Write back a fused mean and advance the axis
    if (fwr) begin
      if (cmd_r == ppif_pkg::CMD_CALIB) begin
        if (kk == 2'd0) ch_nxt = fmean[15:0];
        else cp_nxt[pidx] = fmean;
        nl = {1'b0, cl_r[kk]} + {9'd0, inj_r};
        cl_nxt[kk] = (nl > {1'b0, ppif_pkg::LEVEL_CAP}) ? ppif_pkg::LEVEL_CAP : nl[31:0];
      end else begin
        if (kk == 2'd0) eh_nxt = fmean[15:0];
        else ep_nxt[pidx] = fmean;
      end
      if (kk == 2'd2) begin
        k_nxt     = 3'd0;
        state_nxt = ppif_pkg::S_DONE;
      end else begin
        k_nxt     = k_r + 3'd1;
        state_nxt = (cmd_r == ppif_pkg::CMD_CALIB) ? ppif_pkg::S_CAL_INJ : ppif_pkg::S_FU_X;
      end
    end
  end

  // Control and hypothesis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppif_pkg::S_IDLE;
      k_r     <= '0;
      ih_r    <= '0;
      ch_r    <= '0;
      eh_r    <= '0;
      ip_r[0] <= '0;
      ip_r[1] <= '0;
      cp_r[0] <= '0;
      cp_r[1] <= '0;
      ep_r[0] <= '0;
      ep_r[1] <= '0;
      il_r[0] <= {8'h00, ppif_pkg::HTOT_RST};
      il_r[1] <= {8'h00, ppif_pkg::PTOT_RST};
      il_r[2] <= {8'h00, ppif_pkg::PTOT_RST};
      cl_r[0] <= ppif_pkg::HLVL_TENTH;
      cl_r[1] <= ppif_pkg::PLVL_TENTH;
      cl_r[2] <= ppif_pkg::PLVL_TENTH;
      el_r[0] <= ppif_pkg::HLVL_TENTH;
      el_r[1] <= ppif_pkg::PLVL_TENTH;
      el_r[2] <= ppif_pkg::PLVL_TENTH;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      ih_r    <= ih_nxt;
      ch_r    <= ch_nxt;
      eh_r    <= eh_nxt;
      ip_r    <= ip_nxt;
      cp_r    <= cp_nxt;
      ep_r    <= ep_nxt;
      il_r    <= il_nxt;
      cl_r    <= cl_nxt;
      el_r    <= el_nxt;
    end
  end

  // Item fields and working registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    spd_r  <= spd_nxt;
    trn_r  <= trn_nxt;
    dt_r   <= dt_nxt;
    cueh_r <= cueh_nxt;
    cuex_r <= cuex_nxt;
    cuey_r <= cuey_nxt;
    x2_r   <= x2_nxt;
    trig_r <= trig_nxt;
    tneg_r <= tneg_nxt;
    m_r    <= m_nxt;
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
    inj_r  <= inj_nxt;
  end

  assign idle = (state_r == ppif_pkg::S_IDLE);
  assign done = (state_r == ppif_pkg::S_DONE);

  assign est.heading       = eh_r;
  assign est.x             = ep_r[0];
  assign est.y             = ep_r[1];
  assign est.heading_level = el_r[0];
  assign est.x_level       = el_r[1];
  assign est.y_level       = el_r[2];

endmodule

[hdl/pose_path_integration_fusion_top.sv]
// Two-hypothesis pose tracker (heading, x, y on a torus) with fused estimate.
// Input channel in_*: one beat per command; in_tuser carries the command
// (motion, calibrate, reset calibrated), in_tdata the motion and cue fields.
// Output channel out_*: exactly one beat per input beat, the stored estimate
// (heading, x, y and their activity levels) after the command has acted.
// Configuration: cfg_we/cfg_idx/cfg_data write one register per cycle; write
// only while no command is in flight.
// Every command first reduces four positions and two cues modulo the box
// period on the shared divider (six divisions). A reset command then
// finishes; a calibrate command adds three fusions; a motion command adds
// the heading step, sine and cosine, position steps and three axes of
// renormalisation and fusion. All multiplies share one registered 32x32
// multiplier and all divisions one bit-serial divider. One command is in
// flight at a time.
// A finished estimate waits in the output register; while the receiver
// stalls the next command is still taken and runs, and holds its result
// until the output register is free.
// Reset (rst_n low, synchronous) restores the registers and both hypotheses.
module pose_path_integration_fusion_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [127:0]                          in_tdata,  // speed, turn_rate, step_time,
                                                           // cue_heading, cue_x, cue_y
  input  logic [1:0]                            in_tuser,  // cmd
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [159:0]                          out_tdata, // est_heading, est_x, est_y,
                                                           // est_heading_level, est_x_level,
                                                           // est_y_level
  input  logic                                  cfg_we,
  input  logic [ppif_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [ppif_pkg::CFG_DATA_W-1:0]       cfg_data
);

  ppif_pkg::cfg_t  cfg_r;
  ppif_pkg::item_t item;
  ppif_pkg::est_t  est;
  logic            seq_idle;
  logic            seq_done;
  logic            ack;
  logic            out_valid_r;
  logic [159:0]    out_data_r;

  // Unpack the input beat
  assign item.cmd         = in_tuser;
  assign item.speed       = in_tdata[23:0];
  assign item.turn_rate   = in_tdata[47:24];
  assign item.step_time   = in_tdata[63:48];
  assign item.cue_heading = in_tdata[79:64];
  assign item.cue_x       = in_tdata[103:80];
  assign item.cue_y       = in_tdata[127:104];

  assign in_tready = seq_idle;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box  <= ppif_pkg::BOX_RST;
      cfg_r.htot <= ppif_pkg::HTOT_RST;
      cfg_r.ptot <= ppif_pkg::PTOT_RST;
      cfg_r.inh  <= ppif_pkg::INH_RST;
      cfg_r.inj  <= ppif_pkg::INJ_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ppif_pkg::CFG_BOX:  cfg_r.box  <= cfg_data[7:0];
        ppif_pkg::CFG_HTOT: cfg_r.htot <= cfg_data;
        ppif_pkg::CFG_PTOT: cfg_r.ptot <= cfg_data;
        ppif_pkg::CFG_INH:  cfg_r.inh  <= cfg_data[15:0];
        ppif_pkg::CFG_INJ:  cfg_r.inj  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ppif_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_tvalid & seq_idle),
    .item  (item),
    .cfg   (cfg_r),
    .ack   (ack),
    .idle  (seq_idle),
    .done  (seq_done),
    .est   (est)
  );

  // Output register: load a finished estimate once the slot is free
  assign ack = seq_done && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ack) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) out_data_r <= est;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
